// File: rtl/ism_pkg.sv
// Shared types, codes and the rewrite function of the invocation match table.
`default_nettype none

package ism_pkg;

  localparam int unsigned NUM_BYTES  = 5;
  localparam int unsigned BYTES_W    = 8 * NUM_BYTES;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned LEN_W      = 3;
  localparam logic [7:0]  NOP_BYTE   = 8'h00;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_LOOKUP = 1'b1
  } action_t;

  // Probe that walks down the cell chain during a lookup.
  typedef struct packed {
    logic               vld;
    logic [KEY_W-1:0]   class_key;
    logic [KEY_W-1:0]   method_key;
    logic [LEN_W-1:0]   instr_length;
    logic               hit;
    logic [LEN_W-1:0]   len;
    logic [BYTES_W-1:0] bytes;
  } probe_t;

  // Entry written into one cell by an insert.
  typedef struct packed {
    logic [KEY_W-1:0]   class_key;
    logic [KEY_W-1:0]   method_key;
    logic [LEN_W-1:0]   len;
    logic [BYTES_W-1:0] bytes;
  } entry_t;

  // Replacement bytes up to the shorter of both lengths, NOP elsewhere.
  function automatic logic [BYTES_W-1:0] rewrite(input logic [LEN_W-1:0]   rlen,
                                                 input logic [BYTES_W-1:0] rbytes,
                                                 input logic [LEN_W-1:0]   ilen);
    logic [BYTES_W-1:0] r;
    r = '0;
    for (int j = 0; j < NUM_BYTES; j++) begin
      if (LEN_W'(j) < ilen) begin
        r[8*j +: 8] = (LEN_W'(j) < rlen) ? rbytes[8*j +: 8] : NOP_BYTE;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/ism_if.sv
// Valid/ready channel interfaces for items and results.
`default_nettype none

interface ism_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [ism_pkg::KEY_W-1:0]     class_key;
  logic [ism_pkg::KEY_W-1:0]     method_key;
  logic [ism_pkg::LEN_W-1:0]     repl_length;
  logic [ism_pkg::BYTES_W-1:0]   repl_bytes;
  logic [ism_pkg::LEN_W-1:0]     instr_length;

  modport source (output valid, action, class_key, method_key, repl_length, repl_bytes,
                  instr_length, input ready);
  modport sink   (input valid, action, class_key, method_key, repl_length, repl_bytes,
                  instr_length, output ready);
endinterface

interface ism_out_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic                          status;
  logic [ism_pkg::BYTES_W-1:0]   new_instr;

  modport source (output valid, hit, status, new_instr, input ready);
  modport sink   (input valid, hit, status, new_instr, output ready);
endinterface

`default_nettype wire

// File: rtl/ism_cell.sv
// One table entry with its key compare and a probe register toward the next cell.
`default_nettype none

module ism_cell #(
  parameter int unsigned CW  = 6,
  parameter int unsigned IDX = 0
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire logic            wr_en,
  input  wire ism_pkg::entry_t wr_entry,
  input  wire logic [CW-1:0]   count,
  input  wire ism_pkg::probe_t probe_in,
  output ism_pkg::probe_t      probe_out
);

  ism_pkg::entry_t ent_r;
  ism_pkg::probe_t probe_r;
  ism_pkg::probe_t probe_nxt;
  logic            match;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_r <= wr_entry;
    end
  end

  // Only cells below the fill count hold a written entry.
  assign match = (CW'(IDX) < count) &&
                 (ent_r.class_key == probe_in.class_key) &&
                 (ent_r.method_key == probe_in.method_key);

  always_comb begin
    probe_nxt = probe_in;
    if (!probe_in.hit && match) begin
      probe_nxt.hit   = 1'b1;
      probe_nxt.len   = ent_r.len;
      probe_nxt.bytes = ent_r.bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r.vld <= 1'b0;
    end else if (adv) begin
      probe_r <= probe_nxt;
    end
  end

  assign probe_out = probe_r;

endmodule

`default_nettype wire

// File: rtl/invoke_substitution_match_table.sv
// Top level of the invocation match table: cell chain, fill count and result register.
//
//   channel | dir | handshake     | payload
//   in_ch   | in  | valid / ready | action, class_key, method_key, repl_length,
//           |     |               | repl_bytes, instr_length
//   out_ch  | out | valid / ready | hit, status, new_instr
//
// An insert's result is registered and shows in the cycle after it is taken. A
// lookup walks the chain of TABLE_DEPTH cells, one cell per cycle while the
// chain advances, and its result is registered from the last cell of the chain.
// One item is in the block at a time. Reset empties the table at once.
// A stalled result holds the chain; the next item is taken as the result leaves.
`default_nettype none

module invoke_substitution_match_table #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ism_in_if.sink     in_ch,
  ism_out_if.source  out_ch
);

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  ism_pkg::probe_t            link [0:TABLE_DEPTH];
  ism_pkg::probe_t            head;
  ism_pkg::entry_t            wr_entry;
  logic [CW-1:0]              entry_count_r;
  logic [CW-1:0]              entry_count_nxt;
  logic                       busy_r;
  logic                       busy_nxt;
  logic                       out_vld_r;
  logic                       out_vld_nxt;
  logic                       out_hit_r;
  logic                       out_hit_nxt;
  logic                       out_status_r;
  logic                       out_status_nxt;
  logic [ism_pkg::BYTES_W-1:0] out_instr_r;
  logic [ism_pkg::BYTES_W-1:0] out_instr_nxt;
  logic                       in_fire;
  logic                       is_insert;
  logic                       full;
  logic                       ins_ok;
  logic                       load_look;
  logic                       adv;
  ism_pkg::probe_t            tail;

  assign in_ch.ready = !busy_r && (!out_vld_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign is_insert   = (in_ch.action == ism_pkg::ACT_INSERT);
  assign full        = (entry_count_r == CW'(TABLE_DEPTH));
  assign ins_ok      = in_fire && is_insert && !full;

  assign tail      = link[TABLE_DEPTH];
  assign load_look = tail.vld && (!out_vld_r || out_ch.ready);
  // Hold the chain while a finished lookup waits for the result register.
  assign adv       = !(tail.vld && out_vld_r && !out_ch.ready);

  always_comb begin
    head              = '0;
    head.vld          = in_fire && !is_insert;
    head.class_key    = in_ch.class_key;
    head.method_key   = in_ch.method_key;
    head.instr_length = in_ch.instr_length;
  end

  assign link[0] = head;

  assign wr_entry = {in_ch.class_key, in_ch.method_key, in_ch.repl_length, in_ch.repl_bytes};

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    ism_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .wr_en     (ins_ok && (entry_count_r == CW'(i))),
      .wr_entry  (wr_entry),
      .count     (entry_count_r),
      .probe_in  (link[i]),
      .probe_out (link[i+1])
    );
  end

  always_comb begin
    entry_count_nxt = entry_count_r + CW'(ins_ok);
    busy_nxt        = busy_r;
    if (in_fire && !is_insert) begin
      busy_nxt = 1'b1;
    end else if (load_look) begin
      busy_nxt = 1'b0;
    end

    out_vld_nxt    = out_vld_r && !out_ch.ready;
    out_hit_nxt    = out_hit_r;
    out_status_nxt = out_status_r;
    out_instr_nxt  = out_instr_r;
    if (in_fire && is_insert) begin
      out_vld_nxt    = 1'b1;
      out_hit_nxt    = 1'b0;
      out_status_nxt = full;
      out_instr_nxt  = '0;
    end else if (load_look) begin
      out_vld_nxt    = 1'b1;
      out_hit_nxt    = tail.hit;
      out_status_nxt = 1'b0;
      out_instr_nxt  = tail.hit ? ism_pkg::rewrite(tail.len, tail.bytes, tail.instr_length)
                                : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
      busy_r        <= 1'b0;
      out_vld_r     <= 1'b0;
    end else begin
      entry_count_r <= entry_count_nxt;
      busy_r        <= busy_nxt;
      out_vld_r     <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r    <= out_hit_nxt;
    out_status_r <= out_status_nxt;
    out_instr_r  <= out_instr_nxt;
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.hit       = out_hit_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.new_instr = out_instr_r;

endmodule

`default_nettype wire

// File: rtl/ism_checker.sv
// Port-level checks of the invocation match table, bound to its top level.
`default_nettype none

module ism_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          in_action,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          out_hit,
  input wire logic                          out_status,
  input wire logic [ism_pkg::BYTES_W-1:0]   out_new_instr
);

  // An insert result follows in the next cycle and never hits.
  a_insert_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == ism_pkg::ACT_INSERT)
    |=> out_valid && !out_hit && (out_new_instr == '0))
    else $error("insert item gave no clean result in the next cycle");

  // A lookup owns the block until its result leaves the chain.
  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == ism_pkg::ACT_LOOKUP) |=> !in_ready)
    else $error("item taken while a lookup is in flight");

  a_status_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> !out_hit && (out_new_instr == '0))
    else $error("table-full result carries hit data");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> (out_new_instr == '0))
    else $error("miss result has nonzero instruction bytes");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) && $stable(out_status) &&
                                $stable(out_new_instr))
    else $error("stalled result changed");

endmodule

bind invoke_substitution_match_table ism_checker u_ism_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_action     (in_ch.action),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_hit       (out_ch.hit),
  .out_status    (out_ch.status),
  .out_new_instr (out_ch.new_instr)
);

`default_nettype wire

// File: test/tb.sv
// Testbench for the invocation match table: predictor, scoreboard, directed and random traffic.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned TABLE_DEPTH  = 32;
  localparam int unsigned RANDOM_ITEMS = 1750;
  localparam int unsigned DRAIN_CYCLES = TABLE_DEPTH + 10;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;

  typedef logic [ism_pkg::KEY_W-1:0]   key_t;
  typedef logic [ism_pkg::LEN_W-1:0]   len_t;
  typedef logic [ism_pkg::BYTES_W-1:0] bytes_t;

  typedef struct {
    ism_pkg::action_t action;
    key_t    class_key;
    key_t    method_key;
    len_t    repl_length;
    bytes_t  repl_bytes;
    len_t    instr_length;
  } invoke_item_t;

  typedef struct {
    logic   hit;
    logic   status;
    bytes_t new_instr;
  } rewrite_result_t;

  class rewrite_scoreboard;
    key_t            tbl_class[TABLE_DEPTH];
    key_t            tbl_method[TABLE_DEPTH];
    len_t            tbl_len[TABLE_DEPTH];
    bytes_t          tbl_bytes[TABLE_DEPTH];
    int unsigned     fill;
    int unsigned     error_count;
    rewrite_result_t expected_rewrites[$];

    function new();
      fill = 0;
      error_count = 0;
    endfunction

    // Replacement bytes up to both lengths (each capped at five), NOP after.
    function bytes_t padded_rewrite(len_t rlen, bytes_t rbytes, len_t ilen);
      bytes_t      r;
      int unsigned keep;
      int unsigned span;
      r = '0;
      keep = (rlen > ism_pkg::NUM_BYTES) ? ism_pkg::NUM_BYTES : rlen;
      span = (ilen > ism_pkg::NUM_BYTES) ? ism_pkg::NUM_BYTES : ilen;
      for (int j = 0; j < span; j++) begin
        r[8*j +: 8] = (j < keep) ? rbytes[8*j +: 8] : ism_pkg::NOP_BYTE;
      end
      return r;
    endfunction

    function void note_invocation(invoke_item_t it);
      rewrite_result_t res;
      res.hit = 1'b0;
      res.status = 1'b0;
      res.new_instr = '0;
      if (it.action == ism_pkg::ACT_INSERT) begin
        if (fill >= TABLE_DEPTH) begin
          res.status = 1'b1;
        end else begin
          tbl_class[fill]  = it.class_key;
          tbl_method[fill] = it.method_key;
          tbl_len[fill]    = it.repl_length;
          tbl_bytes[fill]  = it.repl_bytes;
          fill++;
        end
      end else begin
        // earliest matching entry wins
        for (int i = 0; i < fill; i++) begin
          if (tbl_class[i] == it.class_key && tbl_method[i] == it.method_key) begin
            res.hit = 1'b1;
            res.new_instr = padded_rewrite(tbl_len[i], tbl_bytes[i], it.instr_length);
            break;
          end
        end
      end
      expected_rewrites.push_back(res);
    endfunction

    function void check_result(rewrite_result_t got);
      rewrite_result_t want;
      if (expected_rewrites.size() == 0) begin
        $error("unexpected result: hit=%0b status=%0b new_instr=%h",
               got.hit, got.status, got.new_instr);
        error_count++;
        return;
      end
      want = expected_rewrites.pop_front();
      if (got.hit !== want.hit) begin
        $error("hit: expected %0b, actual %0b", want.hit, got.hit);
        error_count++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0b, actual %0b", want.status, got.status);
        error_count++;
      end
      if (got.new_instr !== want.new_instr) begin
        $error("new_instr: expected %h, actual %h", want.new_instr, got.new_instr);
        error_count++;
      end
    endfunction

    function int unsigned pending();
      return expected_rewrites.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int unsigned cycle_count = 0;
  rewrite_scoreboard sb = new();

  ism_in_if  in_ch();
  ism_out_if out_ch();

  invoke_substitution_match_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bytes_t random_bytes();
    return bytes_t'({$urandom, $urandom});
  endfunction

  function automatic invoke_item_t random_item();
    invoke_item_t it;
    it.action       = ism_pkg::action_t'($urandom_range(0, 1));
    it.class_key    = $urandom;
    it.method_key   = $urandom;
    it.repl_length  = len_t'($urandom_range(0, 7));
    it.repl_bytes   = random_bytes();
    it.instr_length = len_t'($urandom_range(0, 7));
    return it;
  endfunction

  function automatic invoke_item_t make_insert(key_t ck, key_t mk, int unsigned rlen,
                                               bytes_t rbytes);
    invoke_item_t it;
    it = random_item();
    it.action      = ism_pkg::ACT_INSERT;
    it.class_key   = ck;
    it.method_key  = mk;
    it.repl_length = len_t'(rlen);
    it.repl_bytes  = rbytes;
    return it;
  endfunction

  function automatic invoke_item_t make_lookup(key_t ck, key_t mk, int unsigned ilen);
    invoke_item_t it;
    it = random_item();
    it.action       = ism_pkg::ACT_LOOKUP;
    it.class_key    = ck;
    it.method_key   = mk;
    it.instr_length = len_t'(ilen);
    return it;
  endfunction

  // Reuse stored keys often so that duplicates and shadowed entries show up.
  function automatic invoke_item_t random_insert();
    invoke_item_t it;
    int unsigned  sel;
    int unsigned  pick;
    it = random_item();
    it.action = ism_pkg::ACT_INSERT;
    sel = $urandom_range(0, 9);
    if (sb.fill > 0 && sel < 3) begin
      pick = $urandom_range(0, sb.fill - 1);
      it.class_key = sb.tbl_class[pick];
      if (sel < 2) it.method_key = sb.tbl_method[pick];
    end
    if ($urandom_range(0, 3) != 0) it.repl_length = len_t'($urandom_range(1, 5));
    return it;
  endfunction

  function automatic invoke_item_t random_lookup();
    invoke_item_t it;
    int unsigned  sel;
    it = random_item();
    it.action = ism_pkg::ACT_LOOKUP;
    sel = $urandom_range(0, 9);
    if (sb.fill > 0 && sel < 8) begin
      it.class_key  = sb.tbl_class[$urandom_range(0, sb.fill - 1)];
      // near miss: class of one entry, method of an entry drawn apart from it
      it.method_key = sb.tbl_method[(sel < 6) ? 0 : $urandom_range(0, sb.fill - 1)];
      if (sel < 6) begin
        int unsigned pick;
        pick = $urandom_range(0, sb.fill - 1);
        it.class_key  = sb.tbl_class[pick];
        it.method_key = sb.tbl_method[pick];
      end
    end
    if ($urandom_range(0, 9) < 7) it.instr_length = ($urandom_range(0, 1) != 0) ? 3'd5 : 3'd3;
    return it;
  endfunction

  // Hold valid across back-to-back items; lower it only for a real gap.
  task automatic send_invocation(input invoke_item_t it, input int unsigned gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= it.action;
    in_ch.class_key    <= it.class_key;
    in_ch.method_key   <= it.method_key;
    in_ch.repl_length  <= it.repl_length;
    in_ch.repl_bytes   <= it.repl_bytes;
    in_ch.instr_length <= it.instr_length;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_invocation(it);
  endtask

  initial begin : stimulus
    invoke_item_t directed[$];
    invoke_item_t it;
    bit           source_burst;

    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.action       <= ism_pkg::ACT_INSERT;
    in_ch.class_key    <= '0;
    in_ch.method_key   <= '0;
    in_ch.repl_length  <= '0;
    in_ch.repl_bytes   <= '0;
    in_ch.instr_length <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, key extremes, odd lengths, a shadowed duplicate
    directed.push_back(make_lookup('0, '0, 3));
    directed.push_back(make_insert('0, '0, 5, '1));
    directed.push_back(make_insert('1, '1, 0, random_bytes()));
    directed.push_back(make_insert(32'h1234_5678, 32'hCAFE_0001, 7, 40'h01_0203_0405));
    directed.push_back(make_insert(32'h1234_5678, 32'hCAFE_0002, 6, random_bytes()));
    directed.push_back(make_insert('0, '0, 1, 40'hAA_AAAA_AAAA));
    directed.push_back(make_insert(32'h5555_5555, 32'hAAAA_AAAA, 3, random_bytes()));
    directed.push_back(make_insert(32'hAAAA_AAAA, 32'h5555_5555, 2, random_bytes()));
    directed.push_back(make_insert(32'h0000_0001, 32'h8000_0000, 4, random_bytes()));
    for (int k = 0; k < 8; k++) directed.push_back(make_lookup('0, '0, k));
    directed.push_back(make_lookup('1, '1, 5));
    directed.push_back(make_lookup(32'h1234_5678, 32'hCAFE_0001, 5));
    directed.push_back(make_lookup(32'h1234_5678, 32'hCAFE_0001, 3));
    directed.push_back(make_lookup(32'h1234_5678, 32'hCAFE_0002, 7));
    directed.push_back(make_lookup(32'h1234_5678, 32'hCAFE_0003, 5));
    directed.push_back(make_lookup(32'h5555_5555, 32'h5555_5555, 3));
    directed.push_back(make_lookup(32'hAAAA_AAAA, 32'h5555_5555, 5));
    directed.push_back(make_lookup(32'h5555_5555, 32'hAAAA_AAAA, 4));

    source_burst = 1'b0;
    foreach (directed[i]) send_invocation(directed[i], $urandom_range(0, 9));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) source_burst = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_ITEMS / 2) begin
        // drain the block completely before going on
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      it = ($urandom_range(0, 99) < 12) ? random_insert() : random_lookup();
      send_invocation(it, source_burst ? 0 : $urandom_range(0, 9));
    end
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hold ready low on a result for the drawn number of cycles, or keep it high.
  initial begin : result_sink
    rewrite_result_t got;
    int unsigned     stall;
    int unsigned     seen;
    bit              sink_burst;

    out_ch.ready <= 1'b0;
    seen = 0;
    sink_burst = 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (seen % 64 == 0) sink_burst = ($urandom_range(0, 3) == 0);
      stall = sink_burst ? 0 : $urandom_range(0, 9);
      if (stall == 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        do @(posedge clk); while (!out_ch.valid);
        repeat (stall - 1) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
      do @(posedge clk); while (!out_ch.valid);
      got.hit       = out_ch.hit;
      got.status    = out_ch.status;
      got.new_instr = out_ch.new_instr;
      sb.check_result(got);
      seen++;
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

endmodule
